@@ rtl/sbgeq_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, command codes and datapath control types for the stereo graphic equalizer.
package sbgeq_pkg;

    localparam int NUM_BANDS_DEF    = 7;
    localparam int NUM_CHANNELS_DEF = 2;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int COEF_BITS_DEF    = 32;

    localparam int NUM_SLOTS       = 5;
    localparam int STATE_BITS      = 48;
    localparam int GUARD_BITS      = 16;
    localparam int COEF_SCALE_BITS = 20;
    localparam int BAND_SEL_BITS   = 3;
    localparam int COEF_IDX_BITS   = 3;

    localparam logic [COEF_IDX_BITS-1:0] SLOT_B0 = 3'd0;

    typedef enum logic [1:0] {
        CMD_PROCESS = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ALU_NONE = 3'd0,
        ALU_Y    = 3'd1,
        ALU_ACC1 = 3'd2,
        ALU_ACC2 = 3'd3,
        ALU_SUB1 = 3'd4
    } alu_op_t;

    typedef struct packed {
        logic    mul_y;
        alu_op_t op;
    } alu_ctrl_t;

endpackage

@@ rtl/stereo_biquad_graphic_eq_top.sv @@
`timescale 1ns / 1ps
// Stereo graphic equalizer top level: request sequencer over coefficient and delay memories.
//
// Each channel runs through NUM_BANDS cascaded transposed direct form II biquads, band 0 first,
// sections interleaved left/right. Coefficients (Q4.28) and delay states live in synchronous
// memories; one shared multiplier walks each section through read, b0, y, z1, z2, subtract and
// write-back steps; a process request finishes into the output register before new requests are taken.
// Write-coefficient and clear requests return nothing; clear zeroes all delay
// states at once. Coefficients read as unity passthrough until written. Out-of-range writes
// and command 3 are ignored. With one channel the right sample passes through unfiltered.
// A finished result sits in an output register, and new requests are taken while it waits.
module stereo_biquad_graphic_eq_top #(
    parameter int NUM_BANDS    = sbgeq_pkg::NUM_BANDS_DEF,
    parameter int NUM_CHANNELS = sbgeq_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = sbgeq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS    = sbgeq_pkg::COEF_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              cmd,
    input  logic signed [SAMPLE_BITS-1:0]           left_in,
    input  logic signed [SAMPLE_BITS-1:0]           right_in,
    input  logic [sbgeq_pkg::BAND_SEL_BITS-1:0]     band_sel,
    input  logic                                    chan_sel,
    input  logic [sbgeq_pkg::COEF_IDX_BITS-1:0]     coef_index,
    input  logic signed [COEF_BITS-1:0]             coef_value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [SAMPLE_BITS-1:0]           left_out,
    output logic signed [SAMPLE_BITS-1:0]           right_out
);

    localparam int NS     = NUM_BANDS * NUM_CHANNELS;
    localparam int CDEPTH = NS * sbgeq_pkg::NUM_SLOTS;
    localparam int CA_W   = $clog2(CDEPTH);
    localparam int SEC_W  = (NS > 1) ? $clog2(NS) : 1;
    localparam int ZW     = sbgeq_pkg::STATE_BITS;

    localparam logic [2:0] STEP_RD  = 3'd0;
    localparam logic [2:0] STEP_B0  = 3'd1;
    localparam logic [2:0] STEP_Y   = 3'd2;
    localparam logic [2:0] STEP_Z1  = 3'd3;
    localparam logic [2:0] STEP_Z2  = 3'd4;
    localparam logic [2:0] STEP_SUB = 3'd5;
    localparam logic [2:0] STEP_WB  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } fsm_t;

    fsm_t                    state_reg, state_next;
    logic [2:0]              step_reg, step_next;
    logic [SEC_W-1:0]        sec_reg, sec_next;
    logic                    ch_reg, ch_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] v_reg [2];
    logic signed [SAMPLE_BITS-1:0] v_next [2];
    logic signed [SAMPLE_BITS-1:0] left_out_reg, left_out_next;
    logic signed [SAMPLE_BITS-1:0] right_out_reg, right_out_next;

    logic                    accept;
    logic                    in_range;
    logic                    cwr_en;
    logic [CA_W-1:0]         cwr_addr;
    logic                    crd_en;
    logic [CA_W-1:0]         crd_addr;
    logic signed [COEF_BITS-1:0] coef_rd;
    logic                    dclr, dwr_en, drd_en;
    logic signed [ZW-1:0]    z1_rd, z2_rd, z1_new, z2_new;
    logic signed [SAMPLE_BITS-1:0] x_cur, y_cur;
    sbgeq_pkg::alu_ctrl_t    alu_ctrl;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign in_range = (int'(band_sel) < NUM_BANDS) && (int'(chan_sel) < NUM_CHANNELS)
                   && (int'(coef_index) < sbgeq_pkg::NUM_SLOTS);
    assign cwr_en   = accept && (cmd == sbgeq_pkg::CMD_WRITE) && in_range;
    assign cwr_addr = CA_W'((CA_W'(band_sel) * CA_W'(NUM_CHANNELS) + CA_W'(chan_sel))
                      * CA_W'(sbgeq_pkg::NUM_SLOTS) + CA_W'(coef_index));

    assign crd_en   = (state_reg == ST_RUN) && (step_reg <= STEP_Z2);
    assign crd_addr = CA_W'(CA_W'(sec_reg) * CA_W'(sbgeq_pkg::NUM_SLOTS) + CA_W'(step_reg));

    assign dclr   = accept && (cmd == sbgeq_pkg::CMD_CLEAR);
    assign drd_en = (state_reg == ST_RUN) && (step_reg == STEP_RD);
    assign dwr_en = (state_reg == ST_RUN) && (step_reg == STEP_WB);

    assign x_cur = v_reg[ch_reg];

    always_comb
    begin
        alu_ctrl.mul_y = (step_reg == STEP_Z2) || (step_reg == STEP_SUB);
        unique case (step_reg)
            STEP_Y:   alu_ctrl.op = sbgeq_pkg::ALU_Y;
            STEP_Z1:  alu_ctrl.op = sbgeq_pkg::ALU_ACC1;
            STEP_Z2:  alu_ctrl.op = sbgeq_pkg::ALU_ACC2;
            STEP_SUB: alu_ctrl.op = sbgeq_pkg::ALU_SUB1;
            default:  alu_ctrl.op = sbgeq_pkg::ALU_NONE;
        endcase
    end

    sbgeq_coef_mem #(
        .DEPTH     (CDEPTH),
        .COEF_BITS (COEF_BITS),
        .AW        (CA_W)
    ) u_coef_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cwr_en),
        .wr_addr (cwr_addr),
        .wr_data (coef_value),
        .rd_en   (crd_en),
        .rd_addr (crd_addr),
        .rd_slot (step_reg),
        .rd_data (coef_rd)
    );

    sbgeq_delay_mem #(
        .DEPTH (NS),
        .AW    (SEC_W)
    ) u_delay_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (dclr),
        .wr_en   (dwr_en),
        .wr_addr (sec_reg),
        .wr_z1   (z1_new),
        .wr_z2   (z2_new),
        .rd_en   (drd_en),
        .rd_addr (sec_reg),
        .rd_z1   (z1_rd),
        .rd_z2   (z2_rd)
    );

    sbgeq_alu #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_alu (
        .clk    (clk),
        .ctrl   (alu_ctrl),
        .x      (x_cur),
        .coef   (coef_rd),
        .z1     (z1_rd),
        .z2     (z2_rd),
        .y      (y_cur),
        .z1_new (z1_new),
        .z2_new (z2_new)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sec_next       = sec_reg;
        ch_next        = ch_reg;
        v_next[0]      = v_reg[0];
        v_next[1]      = v_reg[1];
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == sbgeq_pkg::CMD_PROCESS))
                begin
                    v_next[0]  = left_in;
                    v_next[1]  = right_in;
                    sec_next   = '0;
                    ch_next    = 1'b0;
                    step_next  = STEP_RD;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg == STEP_WB)
                begin
                    v_next[ch_reg] = y_cur;
                    step_next      = STEP_RD;
                    if (sec_reg == SEC_W'(NS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sec_next = sec_reg + 1'b1;
                        ch_next  = (NUM_CHANNELS > 1) ? ~ch_reg : 1'b0;
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    left_out_next  = v_reg[0];
                    right_out_next = v_reg[1];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RD;
            sec_reg       <= '0;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sec_reg       <= sec_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg[0]      <= v_next[0];
        v_reg[1]      <= v_next[1];
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

@@ rtl/sbgeq_coef_mem.sv @@
`timescale 1ns / 1ps
// Coefficient store: single-port-write, registered-read memory with per-entry valid bits.
module sbgeq_coef_mem #(
    parameter int DEPTH     = 70,
    parameter int COEF_BITS = 32,
    parameter int AW        = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [AW-1:0]                         wr_addr,
    input  logic signed [COEF_BITS-1:0]           wr_data,
    input  logic                                  rd_en,
    input  logic [AW-1:0]                         rd_addr,
    input  logic [sbgeq_pkg::COEF_IDX_BITS-1:0]   rd_slot,
    output logic signed [COEF_BITS-1:0]           rd_data
);

    localparam logic [COEF_BITS-1:0] COEF_ONE = {3'b000, 1'b1, {(COEF_BITS-4){1'b0}}};

    logic [COEF_BITS-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [COEF_BITS-1:0] data_reg;
    logic                 hit_reg;
    logic                 b0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem_reg[rd_addr];
            hit_reg  <= valid_reg[rd_addr];
            b0_reg   <= (rd_slot == sbgeq_pkg::SLOT_B0);
        end
    end

    // unwritten entries read as unity passthrough
    assign rd_data = hit_reg ? data_reg : (b0_reg ? COEF_ONE : '0);

endmodule

@@ rtl/sbgeq_delay_mem.sv @@
`timescale 1ns / 1ps
// Delay state store: z1/z2 pair per section, registered read, valid bits cleared by reset or clear.
module sbgeq_delay_mem #(
    parameter int DEPTH = 14,
    parameter int AW    = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  clr,
    input  logic                                  wr_en,
    input  logic [AW-1:0]                         wr_addr,
    input  logic signed [sbgeq_pkg::STATE_BITS-1:0] wr_z1,
    input  logic signed [sbgeq_pkg::STATE_BITS-1:0] wr_z2,
    input  logic                                  rd_en,
    input  logic [AW-1:0]                         rd_addr,
    output logic signed [sbgeq_pkg::STATE_BITS-1:0] rd_z1,
    output logic signed [sbgeq_pkg::STATE_BITS-1:0] rd_z2
);

    localparam int ZW = sbgeq_pkg::STATE_BITS;

    logic [2*ZW-1:0]  mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [2*ZW-1:0]  data_reg;
    logic             hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= {wr_z1, wr_z2};
        end
        if (rd_en)
        begin
            data_reg <= mem_reg[rd_addr];
            hit_reg  <= valid_reg[rd_addr];
        end
    end

    assign rd_z1 = hit_reg ? data_reg[2*ZW-1:ZW] : '0;
    assign rd_z2 = hit_reg ? data_reg[ZW-1:0] : '0;

endmodule

@@ rtl/sbgeq_alu.sv @@
`timescale 1ns / 1ps
// Biquad section datapath: shared registered multiplier, accumulators and saturation.
module sbgeq_alu #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic                                    clk,
    input  sbgeq_pkg::alu_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0]           x,
    input  logic signed [COEF_BITS-1:0]             coef,
    input  logic signed [sbgeq_pkg::STATE_BITS-1:0] z1,
    input  logic signed [sbgeq_pkg::STATE_BITS-1:0] z2,
    output logic signed [SAMPLE_BITS-1:0]           y,
    output logic signed [sbgeq_pkg::STATE_BITS-1:0] z1_new,
    output logic signed [sbgeq_pkg::STATE_BITS-1:0] z2_new
);

    localparam int ZW   = sbgeq_pkg::STATE_BITS;
    localparam int GB   = sbgeq_pkg::GUARD_BITS;
    localparam int CS   = sbgeq_pkg::COEF_SCALE_BITS;
    localparam int PW   = SAMPLE_BITS + COEF_BITS;
    localparam int SW   = SAMPLE_BITS + CS;
    localparam int MAXW = (SW > ZW) ? SW : ZW;
    localparam int ACCW = MAXW + 2;
    localparam int YW   = ACCW - GB;

    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [PW-1:0]          prod;
    logic signed [PW+CS-1:0]       prod_ext;
    logic signed [PW+CS-1:0]       prod_scl;
    logic signed [SW-1:0]          p_next, p_reg;
    logic signed [ACCW-1:0]        p_ext, z1_ext, z2_ext, sum_y, y_full;
    logic signed [YW-1:0]          y_sh;
    logic signed [SAMPLE_BITS-1:0] y_next, y_reg;
    logic signed [ACCW-1:0]        acc1_next, acc1_reg, acc2_next, acc2_reg;

    function automatic logic signed [ZW-1:0] sat_state(input logic signed [ACCW-1:0] v);
        logic [ACCW-ZW:0] hi_bits;
        hi_bits = v[ACCW-1:ZW-1];
        if (hi_bits == '0 || hi_bits == '1)
            return v[ZW-1:0];
        else if (v[ACCW-1])
            return {1'b1, {(ZW-1){1'b0}}};
        else
            return {1'b0, {(ZW-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [YW-1:0] v);
        logic [YW-SAMPLE_BITS:0] hi_bits;
        hi_bits = v[YW-1:SAMPLE_BITS-1];
        if (hi_bits == '0 || hi_bits == '1)
            return v[SAMPLE_BITS-1:0];
        else if (v[YW-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    // product scaled by 2^20 / 2^COEF_BITS with floor
    always_comb
    begin
        mul_a    = ctrl.mul_y ? y_reg : x;
        prod     = mul_a * coef;
        prod_ext = signed'({prod, {CS{1'b0}}});
        prod_scl = prod_ext >>> COEF_BITS;
        p_next   = prod_scl[SW-1:0];
    end

    always_comb
    begin
        p_ext  = ACCW'(p_reg);
        z1_ext = ACCW'(z1);
        z2_ext = ACCW'(z2);
        sum_y  = p_ext + z1_ext;
        y_full = sum_y >>> GB;
        y_sh   = y_full[YW-1:0];

        y_next    = y_reg;
        acc1_next = acc1_reg;
        acc2_next = acc2_reg;
        unique case (ctrl.op)
            sbgeq_pkg::ALU_Y:    y_next    = sat_sample(y_sh);
            sbgeq_pkg::ALU_ACC1: acc1_next = p_ext + z2_ext;
            sbgeq_pkg::ALU_ACC2: acc2_next = p_ext;
            sbgeq_pkg::ALU_SUB1: acc1_next = acc1_reg - p_ext;
            default:             y_next    = y_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        y_reg    <= y_next;
        acc1_reg <= acc1_next;
        acc2_reg <= acc2_next;
    end

    assign y      = y_reg;
    assign z1_new = sat_state(acc1_reg);
    assign z2_new = sat_state(acc2_reg - p_ext);

endmodule

@@ rtl/sbgeq_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the stereo graphic equalizer, bound to the top level.
module sbgeq_checker #(
    parameter int SAMPLE_BITS = sbgeq_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [1:0]                    cmd,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] left_out,
    input logic signed [SAMPLE_BITS-1:0] right_out
);

    // a process request keeps the block busy
    a_busy_after_process: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == sbgeq_pkg::CMD_PROCESS) |=> !in_ready)
        else $error("in_ready high right after process request");

    // write, clear and unknown requests produce no result
    a_no_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd != sbgeq_pkg::CMD_PROCESS) && !out_valid |=> !out_valid)
        else $error("result appeared after non-process request");

    // a result only appears out of a busy period
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("stalled result changed");

endmodule

bind stereo_biquad_graphic_eq_top sbgeq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sbgeq_checker (.*);

@@ tb/stereo_biquad_graphic_eq_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the stereo graphic equalizer: queued requests, stalling sink, predictor.
module stereo_biquad_graphic_eq_top_test;
    import sbgeq_pkg::*;

    localparam int NB   = NUM_BANDS_DEF;
    localparam int NCH  = NUM_CHANNELS_DEF;
    localparam int SB   = SAMPLE_BITS_DEF;
    localparam int CB   = COEF_BITS_DEF;
    localparam int NSEC = NB * NCH;

    localparam int REQUEST_TARGET = 950;
    localparam int LONG_HOLD_AT   = 60;
    localparam int LONG_HOLD_LEN  = 800;
    localparam int QUIET_TAIL     = 120;
    localparam int COEF_ONE       = 1 << (CB - 4);

    typedef struct {
        logic                     drain;
        cmd_t                     op;
        logic signed [SB-1:0]     left;
        logic signed [SB-1:0]     right;
        logic [BAND_SEL_BITS-1:0] band;
        logic                     chan;
        logic [COEF_IDX_BITS-1:0] slot;
        logic signed [CB-1:0]     value;
    } eq_request_t;

    typedef struct {
        logic signed [SB-1:0] l;
        logic signed [SB-1:0] r;
    } eq_pair_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               cmd = CMD_NOP;
    logic signed [SB-1:0]     left_in = '0;
    logic signed [SB-1:0]     right_in = '0;
    logic [BAND_SEL_BITS-1:0] band_sel = '0;
    logic                     chan_sel = 1'b0;
    logic [COEF_IDX_BITS-1:0] coef_index = '0;
    logic signed [CB-1:0]     coef_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [SB-1:0]     left_out;
    logic signed [SB-1:0]     right_out;

    eq_request_t request_fifo[$];
    eq_pair_t    expected_pairs[$];

    longint coef_mem[NSEC*NUM_SLOTS];
    longint delay_a[NSEC];
    longint delay_b[NSEC];

    int  err_count = 0;
    int  n_sent = 0;
    int  n_total = 0;
    int  n_results = 0;
    int  n_pairs = 0;
    int  n_writes = 0;
    int  n_clears = 0;
    int  n_ignored = 0;
    int  n_made = 0;
    bit  waiting_drain = 0;
    bit  long_hold_done = 0;

    stereo_biquad_graphic_eq_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .left_in    (left_in),
        .right_in   (right_in),
        .band_sel   (band_sel),
        .chan_sel   (chan_sel),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .left_out   (left_out),
        .right_out  (right_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_bits(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint scaled_product(longint s, longint c);
        return (s * c) >>> (CB - COEF_SCALE_BITS);
    endfunction

    task automatic reset_model();
        for (int i = 0; i < NSEC * NUM_SLOTS; i++)
            coef_mem[i] = (i % NUM_SLOTS == 0) ? longint'(COEF_ONE) : 0;
        for (int i = 0; i < NSEC; i++)
        begin
            delay_a[i] = 0;
            delay_b[i] = 0;
        end
    endtask

    task automatic run_section(input int sec, inout longint x);
        int     base;
        longint y;
        base = sec * NUM_SLOTS;
        y = clamp_bits((scaled_product(x, coef_mem[base]) + delay_a[sec]) >>> GUARD_BITS, SB);
        delay_a[sec] = clamp_bits(scaled_product(x, coef_mem[base+1])
                                  - scaled_product(y, coef_mem[base+3]) + delay_b[sec],
                                  STATE_BITS);
        delay_b[sec] = clamp_bits(scaled_product(x, coef_mem[base+2])
                                  - scaled_product(y, coef_mem[base+4]), STATE_BITS);
        x = y;
    endtask

    task automatic apply_request(input eq_request_t rq);
        longint   lv;
        longint   rv;
        eq_pair_t pr;
        case (rq.op)
            CMD_PROCESS:
            begin
                lv = rq.left;
                rv = rq.right;
                for (int b = 0; b < NB; b++)
                begin
                    run_section(b * NCH, lv);
                    run_section(b * NCH + 1, rv);
                end
                pr.l = SB'(lv);
                pr.r = SB'(rv);
                expected_pairs.push_back(pr);
                n_pairs++;
            end
            CMD_WRITE:
            begin
                if (rq.band < NB && rq.chan < NCH && rq.slot < NUM_SLOTS)
                begin
                    coef_mem[(int'(rq.band) * NCH + int'(rq.chan)) * NUM_SLOTS
                             + int'(rq.slot)] = rq.value;
                    n_writes++;
                end
                else
                    n_ignored++;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < NSEC; i++)
                begin
                    delay_a[i] = 0;
                    delay_b[i] = 0;
                end
                n_clears++;
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic note_mismatch(input string msg);
        err_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // stimulus helpers
    task automatic queue_request(input cmd_t op, input int l, input int r, input int band,
                                 input int chan, input int slot, input int val);
        eq_request_t rq;
        rq.drain = 1'b0;
        rq.op    = op;
        rq.left  = SB'(l);
        rq.right = SB'(r);
        rq.band  = BAND_SEL_BITS'(band);
        rq.chan  = chan[0];
        rq.slot  = COEF_IDX_BITS'(slot);
        rq.value = CB'(val);
        request_fifo.push_back(rq);
        if (op != CMD_NOP && !(op == CMD_WRITE && (band >= NB || slot >= NUM_SLOTS)))
            n_made++;
    endtask

    task automatic queue_pair(input int l, input int r);
        queue_request(CMD_PROCESS, l, r, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic queue_write(input int band, input int chan, input int slot, input int val);
        queue_request(CMD_WRITE, $urandom, $urandom, band, chan, slot, val);
    endtask

    function automatic int pick_sample();
        case ($urandom_range(0, 9))
            0: return (1 << (SB - 1)) - 1;
            1: return -(1 << (SB - 1));
            2: return 0;
            3, 4, 5: return int'($urandom_range(0, 131071)) - 65536;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic int pick_coef();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 0;
            3: return COEF_ONE;
            4, 5: return int'($urandom);
            default: return int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
        endcase
    endfunction

    // request driver
    eq_request_t on_bus;
    int          send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic        nxt_valid;
        eq_request_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            nxt_valid = in_valid;
            if (in_valid && in_ready)
            begin
                apply_request(on_bus);
                n_sent++;
                nxt_valid = 1'b0;
                if (n_sent < n_total - QUIET_TAIL && (n_sent % 256) < 160
                    && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (waiting_drain)
                begin
                    if (expected_pairs.size() == 0)
                        waiting_drain = 0;
                end
                else if (request_fifo.size() > 0)
                begin
                    nxt = request_fifo.pop_front();
                    if (nxt.drain)
                        waiting_drain = 1;
                    else
                    begin
                        on_bus = nxt;
                        cmd        <= nxt.op;
                        left_in    <= nxt.left;
                        right_in   <= nxt.right;
                        band_sel   <= nxt.band;
                        chan_sel   <= nxt.chan;
                        coef_index <= nxt.slot;
                        coef_value <= nxt.value;
                        nxt_valid = 1'b1;
                    end
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // result monitor and sink back-pressure
    int sink_cycle = 0;
    int sink_stall = 0;
    int hold_left  = 0;

    always @(posedge clk or negedge rst_n)
    begin : sink_results
        eq_pair_t pr;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_stall = 0;
            hold_left  = 0;
        end
        else
        begin
            sink_cycle++;
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_pairs.size() == 0)
                    note_mismatch($sformatf("result with none pending: L=%0d R=%0d",
                                            left_out, right_out));
                else
                begin
                    pr = expected_pairs.pop_front();
                    if (left_out !== pr.l)
                        note_mismatch($sformatf("pair %0d left_out got %0d want %0d",
                                                n_results, left_out, pr.l));
                    if (right_out !== pr.r)
                        note_mismatch($sformatf("pair %0d right_out got %0d want %0d",
                                                n_results, right_out, pr.r));
                end
            end
            if (!long_hold_done && n_results == LONG_HOLD_AT)
            begin
                long_hold_done = 1;
                hold_left = LONG_HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (sink_stall > 0)
            begin
                sink_stall--;
                out_ready <= 1'b0;
            end
            else if (n_sent < n_total - QUIET_TAIL && (sink_cycle % 512) < 320
                     && $urandom_range(0, 9) == 0)
            begin
                sink_stall = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        eq_request_t mark;
        int          phase;
        int          band;
        int          chan;
        rst_n = 1'b0;
        reset_model();

        // directed: passthrough extremes, ignored requests, saturation, clear
        queue_pair((1 << (SB - 1)) - 1, -(1 << (SB - 1)));
        queue_pair(-(1 << (SB - 1)), (1 << (SB - 1)) - 1);
        queue_pair(0, -1);
        queue_request(CMD_NOP, $urandom, $urandom, 2, 1, 3, $urandom);
        queue_write(7, 0, 0, 0);
        queue_write(0, 1, 5, 0);
        queue_write(3, 0, 7, 32'h7FFF_FFFF);
        queue_pair(1234567, -7654321);
        queue_write(0, 0, 0, 32'h7FFF_FFFF);
        queue_write(6, 1, 0, 32'h8000_0000);
        queue_pair((1 << (SB - 1)) - 1, (1 << (SB - 1)) - 1);
        queue_pair(-(1 << (SB - 1)), -(1 << (SB - 1)));
        queue_write(3, 0, 1, COEF_ONE);
        queue_write(3, 1, 2, -COEF_ONE);
        queue_write(2, 0, 3, 32'h7FFF_FFFF);
        queue_write(2, 1, 4, 32'h8000_0000);
        queue_pair((1 << (SB - 1)) - 1, -(1 << (SB - 1)));
        queue_pair(-(1 << (SB - 1)), (1 << (SB - 1)) - 1);
        queue_pair(4000000, -4000000);
        queue_request(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        queue_pair(-1, 1);
        queue_write(0, 0, 0, COEF_ONE);
        queue_write(6, 1, 0, COEF_ONE);
        queue_pair(8388607, 12345);

        // random: programmed bands with filtered bursts, plus noise
        phase = 0;
        while (n_made < REQUEST_TARGET)
        begin
            if ($urandom_range(0, 99) < 15)
                queue_request(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
            if ($urandom_range(0, 1) == 0)
            begin
                band = $urandom_range(0, NB - 1);
                chan = $urandom_range(0, 1);
                queue_write(band, chan, 0, COEF_ONE + int'($urandom_range(0, 1 << 27)) - (1 << 26));
                for (int s = 1; s < NUM_SLOTS; s++)
                    queue_write(band, chan, s, int'($urandom_range(0, 1 << 27)) - (1 << 26));
            end
            else
                repeat ($urandom_range(0, 6))
                    queue_write(($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, NB - 1),
                                $urandom_range(0, 1),
                                ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                             : $urandom_range(0, 4),
                                pick_coef());
            if ($urandom_range(0, 19) == 0)
                queue_request(CMD_NOP, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
            repeat ($urandom_range(2, 14))
                queue_pair(pick_sample(), pick_sample());
            phase++;
            if (phase == 40)
            begin
                mark = request_fifo[$];
                mark.drain = 1'b1;
                request_fifo.push_back(mark);
            end
        end
        n_total = request_fifo.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (request_fifo.size() != 0 || in_valid || waiting_drain)
            @(posedge clk);
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("Covered %0d sample pairs, %0d coefficient writes, %0d clears, %0d ignored",
                 n_pairs, n_writes, n_clears, n_ignored);
        $display("Sink hold-off and sender drain pause exercised; %0d mismatches", err_count);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
